/* sv/node_liveness_aging_table_core_defines.svh */
// Assertion macros for the liveness table core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef NODE_LIVENESS_AGING_TABLE_CORE_DEFINES_SVH
`define NODE_LIVENESS_AGING_TABLE_CORE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define NLAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must never hold.
`define NLAT_NEVER(lbl, expr, msg) \
  `NLAT_ASSERT(lbl, !(expr), msg)

`endif

/* sv/nlat_pkg.sv */
// Types and constants shared by the liveness table core.
// No dependencies.
`default_nettype none

package nlat_pkg;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_OFFLINE = 2'd1,
    ST_CLOSED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  localparam int          AGE_W         = 8;
  localparam int          NODE_W        = 5;
  localparam int          CFG_IDX_W     = 2;
  localparam int          MAX_RESULTS   = 32;
  localparam int          CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [AGE_W-1:0] OFFLINE_RESET = 8'd10;
  localparam logic [AGE_W-1:0] CLOSED_RESET  = 8'd20;
  localparam logic [AGE_W-1:0] AGE_RESET     = 8'(CLOSED_RESET + 8'd1);

  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_THR  = 2'd1;

  // One table slot as it moves round the ring.
  typedef struct packed {
    logic [AGE_W-1:0] age;
    status_t          status;
  } slot_t;

  // One result word.
  typedef struct packed {
    logic [NODE_W-1:0] node;
    status_t           state;
    logic              last;
    logic              none;
    logic              bad;
  } out_word_t;

endpackage

`default_nettype wire

/* sv/nlat_cell.sv */
// One storage cell of the slot ring; loads its neighbour's slot on shift.
// Depends on nlat_pkg.
`default_nettype none

module nlat_cell
  import nlat_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  shift_en,
  input  wire slot_t slot_in,
  output slot_t      slot_out
);

  slot_t slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '{age: AGE_RESET, status: ST_CLOSED};
    end else if (shift_en) begin
      slot_r <= slot_in;
    end
  end

  assign slot_out = slot_r;

endmodule

`default_nettype wire

/* sv/nlat_ager.sv */
// Ageing unit at the head of the ring: refresh, age and classify one slot.
// Depends on nlat_pkg.
`default_nettype none

module nlat_ager
  import nlat_pkg::*;
(
  input  wire slot_t            slot_in,
  input  wire logic             refresh,
  input  wire logic [AGE_W-1:0] offline_thr,
  input  wire logic [AGE_W-1:0] closed_thr,
  output slot_t                 slot_out,
  output logic                  listed
);

  logic [AGE_W-1:0] age_in;
  status_t          status_in;
  logic [AGE_W:0]   aged;

  always_comb begin
    age_in    = refresh ? '0 : slot_in.age;
    status_in = refresh ? ST_RUNNING : slot_in.status;
    aged      = {1'b0, age_in} + {{AGE_W{1'b0}}, 1'b1};
    slot_out  = '{age: age_in, status: status_in};
    listed    = 1'b0;
    if (aged > {1'b0, closed_thr}) begin
      // past the closed limit: counter holds, node dropped
      slot_out.status = ST_CLOSED;
    end else begin
      listed       = 1'b1;
      slot_out.age = aged[AGE_W-1:0];
      if (aged > {1'b0, offline_thr}) begin
        slot_out.status = ST_OFFLINE;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/node_liveness_aging_table_core.sv */
// Node liveness table: a ring of NODE_SLOTS cells rotated through one ageing unit.
// Flow: an accept state, then a scan of NODE_SLOTS slots at one slot per cycle while out_stall
// does not hold the scan, then the final word. Out-of-range IDs skip the scan. in_stall stays
// high until the core is back in idle, so a new report waits until the last one is done.
// Reset (sync, rst_n low): every slot closed with age 21, thresholds 10 and 20, no word.
`default_nettype none
`include "node_liveness_aging_table_core_defines.svh"

module node_liveness_aging_table_core
  import nlat_pkg::*;
#(
  parameter int NODE_SLOTS = 32
)
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input words
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_node_id,
  // result words
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [NODE_W-1:0]         out_active_node,
  output logic [1:0]                out_node_state,
  output logic                      out_last_in_run,
  output logic                      out_none_active,
  output logic                      out_bad_id,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [AGE_W-1:0]     cfg_data
);

  localparam int              SW      = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam logic [SW-1:0]   LAST_SL = SW'(NODE_SLOTS - 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RESULTS);

  // ---------------------------------------------------------------------------
  // Thresholds
  // ---------------------------------------------------------------------------
  logic [AGE_W-1:0] offline_thr_r;
  logic [AGE_W-1:0] closed_thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offline_thr_r <= OFFLINE_RESET;
      closed_thr_r  <= CLOSED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OFFLINE_THR: offline_thr_r <= cfg_data;
        CFG_CLOSED_THR:  closed_thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Slot ring. Cell 0 is the head and feeds the ageing unit; the aged slot
  // re-enters at the tail. After NODE_SLOTS shifts slot 0 is back at the head,
  // so slot_r always names the slot sitting at the head.
  // ---------------------------------------------------------------------------
  slot_t ring   [NODE_SLOTS];
  slot_t aged_slot;
  logic  listed;
  logic  shift_en;

  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] target_r, target_nxt;

  for (genvar k = 0; k < NODE_SLOTS; k++) begin : g_ring
    if (k == NODE_SLOTS - 1) begin : g_tail
      nlat_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .slot_in  (aged_slot),
        .slot_out (ring[k])
      );
    end else begin : g_body
      nlat_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .slot_in  (ring[k+1]),
        .slot_out (ring[k])
      );
    end
  end

  nlat_ager u_ager (
    .slot_in     (ring[0]),
    .refresh     (slot_r == target_r),
    .offline_thr (offline_thr_r),
    .closed_thr  (closed_thr_r),
    .slot_out    (aged_slot),
    .listed      (listed)
  );

  // ---------------------------------------------------------------------------
  // Control. A listed node is held back in a pending word for one find so the
  // last one can carry last_in_run once the scan ends.
  // ---------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              bad_r, bad_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  out_word_t         pend_r, pend_nxt;

  out_word_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              out_free;
  logic              take;
  logic              in_range;
  logic              push;
  out_word_t         push_word;

  assign out_free = !out_valid_r || !out_stall;
  assign in_range = {1'b0, in_node_id} < 9'(NODE_SLOTS);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    target_nxt     = target_r;
    cnt_nxt        = cnt_r;
    bad_nxt        = bad_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    shift_en       = 1'b0;
    take           = 1'b0;
    push           = 1'b0;
    push_word      = pend_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_range) begin
            target_nxt = in_node_id[SW-1:0];
            slot_nxt   = '0;
            state_nxt  = S_SCAN;
          end else begin
            bad_nxt   = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end

      S_SCAN: begin
        take = listed && (cnt_r < MAX_CNT);
        // a new find flushes the pending word, which needs the output free
        if (!(take && pend_valid_r) || out_free) begin
          shift_en = 1'b1;
          slot_nxt = slot_r + SW'(1);
          if (take) begin
            push           = pend_valid_r;
            push_word      = pend_r;
            push_word.last = 1'b0;
            pend_nxt       = '{node: NODE_W'(slot_r), state: aged_slot.status,
                               last: 1'b0, none: 1'b0, bad: 1'b0};
            pend_valid_nxt = 1'b1;
            cnt_nxt        = cnt_r + CNT_W'(1);
          end
          if (slot_r == LAST_SL) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          push = 1'b1;
          if (bad_r) begin
            push_word = '{node: '0, state: ST_RUNNING, last: 1'b1, none: 1'b0, bad: 1'b1};
          end else if (pend_valid_r) begin
            push_word      = pend_r;
            push_word.last = 1'b1;
          end else begin
            push_word = '{node: '0, state: ST_RUNNING, last: 1'b1, none: 1'b1, bad: 1'b0};
          end
          bad_nxt        = 1'b0;
          pend_valid_nxt = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_nxt       = push_word;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      bad_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      bad_r        <= bad_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    target_r <= target_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_active_node = out_r.node;
  assign out_node_state  = out_r.state;
  assign out_last_in_run = out_r.last;
  assign out_none_active = out_r.none;
  assign out_bad_id      = out_r.bad;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `NLAT_ASSERT(a_cnt_cap, cnt_r <= MAX_CNT, "listed count above result limit")
  `NLAT_ASSERT(a_pend_cnt, pend_valid_r |-> cnt_r != '0, "pending word without a count")
  `NLAT_ASSERT(a_none_last, out_valid && out_none_active |-> out_last_in_run,
               "empty-list word without last marker")
  `NLAT_NEVER(a_bad_none, out_valid && out_bad_id && out_none_active,
              "bad ID and empty list flagged together")

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for node_liveness_aging_table_core: node reports in, listed words out.
// A scoreboard class keeps its own liveness table and checks every word in order.
// Needs nlat_pkg and the core RTL; nothing else.

module tb
  import nlat_pkg::*;
();

  localparam int SLOTS = 32;
  // Idle cycles with no handshake on any channel before the run is given up.
  localparam int LIMIT = 3000;
  // Index beyond the register file: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Liveness table model plus the queue of words still owed by the core.
  class liveness_board;
    logic [AGE_W-1:0] offline_thr;
    logic [AGE_W-1:0] closed_thr;
    logic [AGE_W-1:0] age[SLOTS];
    status_t          status[SLOTS];
    out_word_t        due_words[$];
    int               errors;

    function new();
      offline_thr = OFFLINE_RESET;
      closed_thr  = CLOSED_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        age[i]    = AGE_RESET;
        status[i] = ST_CLOSED;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [AGE_W-1:0] val);
      case (idx)
        CFG_OFFLINE_THR: offline_thr = val;
        CFG_CLOSED_THR:  closed_thr  = val;
        default: ;
      endcase
    endfunction

    // Refresh the reporting node, age the lot, queue the run of listed nodes.
    function void note_report(logic [7:0] id);
      logic [AGE_W:0] aged;
      out_word_t      w;
      out_word_t      held;
      bit             have;
      int             n;
      w    = '0;
      held = '0;
      have = 0;
      n    = 0;
      if (id >= SLOTS) begin
        w.last = 1'b1;
        w.bad  = 1'b1;
        due_words.push_back(w);
        return;
      end
      age[id]    = '0;
      status[id] = ST_RUNNING;
      for (int i = 0; i < SLOTS; i++) begin
        aged = {1'b0, age[i]} + 1'b1;
        if (aged > closed_thr) begin
          // counter holds its old value, so it can never wrap
          status[i] = ST_CLOSED;
        end else begin
          age[i] = aged[AGE_W-1:0];
          if (aged > offline_thr) status[i] = ST_OFFLINE;
          if (n < MAX_RESULTS) begin
            if (have) due_words.push_back(held);
            held       = '0;
            held.node  = NODE_W'(i);
            held.state = status[i];
            have       = 1;
            n++;
          end
        end
      end
      if (have) begin
        held.last = 1'b1;
        due_words.push_back(held);
      end else begin
        w.last = 1'b1;
        w.none = 1'b1;
        due_words.push_back(w);
      end
    endfunction

    function void cmp_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (due_words.size() == 0) begin
        $display("%0t: word with nothing expected: node %0d state %0d last %0b none %0b bad %0b",
                 $time, got.node, got.state, got.last, got.none, got.bad);
        errors++;
        return;
      end
      want = due_words.pop_front();
      cmp_field("active_node", want.node, got.node);
      cmp_field("node_state", want.state, got.state);
      cmp_field("last_in_run", want.last, got.last);
      cmp_field("none_active", want.none, got.none);
      cmp_field("bad_id", want.bad, got.bad);
    endfunction

    function int pending();
      return due_words.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_node_id = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [NODE_W-1:0]    out_active_node;
  logic [1:0]           out_node_state;
  logic                 out_last_in_run;
  logic                 out_none_active;
  logic                 out_bad_id;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [AGE_W-1:0]     cfg_data = '0;

  liveness_board sb;
  bit            calm = 0;      // phase with no gaps and no stalls
  int            idle_cycles = 0;
  int            stall_left = 0;
  logic [7:0]    crew[8];       // nodes that report often in the current phase
  int            crew_n = 1;

  always #10 clk = ~clk;

  node_liveness_aging_table_core #(.NODE_SLOTS(SLOTS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_node_id      (in_node_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_active_node (out_active_node),
    .out_node_state  (out_node_state),
    .out_last_in_run (out_last_in_run),
    .out_none_active (out_none_active),
    .out_bad_id      (out_bad_id),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Receiver back-pressure: mostly short bursts, now and then a long hold.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (calm) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (r < 55) begin
      out_stall  <= 1'b0;
      stall_left = $urandom_range(1, 8);
    end else if (r < 85) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else if (r < 97) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(3, 11);
    end else begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(20, 50);
    end
  end

  // Monitor: every handshake is sampled on the pre-edge values.
  // Also the watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    out_word_t got;
    bit        moved;
    moved = 0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        moved = 1;
      end
      if (in_valid && !in_stall) begin
        sb.note_report(in_node_id);
        moved = 1;
      end
      if (out_valid && !out_stall) begin
        got.node  = out_active_node;
        got.state = status_t'(out_node_state);
        got.last  = out_last_in_run;
        got.none  = out_none_active;
        got.bad   = out_bad_id;
        sb.check_word(got);
        moved = 1;
      end
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sender gap: often none, mostly short, rarely long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // valid stays high into the next word when there is no gap
  task automatic send_report(input logic [7:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_node_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every owed word is out, then let a full scan's worth pass.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  // Call only after settle(): the core must be idle.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AGE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function logic [AGE_W-1:0] pick_thr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 50) return 8'd254;
    return AGE_W'($urandom_range(0, 254));
  endfunction

  // One random phase: mostly the crew reporting, some stray nodes, some bad IDs.
  task automatic run_phase(input int n);
    int r;
    crew_n = $urandom_range(2, 8);
    for (int k = 0; k < 8; k++) crew[k] = 8'($urandom_range(0, SLOTS - 1));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_report(crew[$urandom_range(0, crew_n - 1)]);
      else if (r < 85) send_report(8'($urandom_range(0, SLOTS - 1)));
      else if (r < 88) send_report(8'hFF);
      else send_report(8'($urandom_range(SLOTS, 255)));
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset thresholds. Bad IDs first, against an all-closed table,
    // then a few nodes left to drift offline while node 7 keeps reporting.
    set_reg(CFG_SPARE, 8'd0);
    send_report(8'hFF);
    send_report(8'd32);
    send_report(8'd128);
    send_report(8'd0);
    send_report(8'd31);
    send_report(8'd5);
    repeat (12) send_report(8'd7);

    // Tight thresholds: the drifting nodes close within a few words.
    settle();
    set_reg(CFG_OFFLINE_THR, 8'd3);
    set_reg(CFG_CLOSED_THR, 8'd5);
    repeat (4) send_report(8'd9);

    // Closed threshold zero: even a fresh report closes at once, so nothing is listed.
    settle();
    set_reg(CFG_CLOSED_THR, 8'd0);
    send_report(8'd12);
    send_report(8'd40);
    send_report(8'd12);

    // Random phases. The first ones raise the closed threshold over closed
    // nodes, which are then listed still carrying their closed status.
    for (int p = 0; p < 8; p++) begin
      settle();
      if (p == 0) begin
        set_reg(CFG_CLOSED_THR, 8'd254);
        set_reg(CFG_OFFLINE_THR, 8'd254);
      end else if (p == 1) begin
        set_reg(CFG_OFFLINE_THR, 8'd0);
      end else if (p == 2) begin
        set_reg(CFG_OFFLINE_THR, OFFLINE_RESET);
        set_reg(CFG_CLOSED_THR, CLOSED_RESET);
      end else begin
        if ($urandom_range(0, 3) != 0) set_reg(CFG_OFFLINE_THR, pick_thr());
        if ($urandom_range(0, 3) != 0) set_reg(CFG_CLOSED_THR, pick_thr());
      end
      calm = ($urandom_range(0, 4) == 0);
      run_phase(30);
      calm = 0;
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/nlat_pkg.sv
sv/nlat_cell.sv
sv/nlat_ager.sv
sv/node_liveness_aging_table_core.sv
tb/tb.sv
